// ===== rtl/core/ahpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ahpd_pkg
// Shared types, codes and helpers for the ASCII hex packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ahpd_pkg;

  // Register map, word index of each configuration register
  localparam int unsigned REG_BEGIN_CHAR    = 0;
  localparam int unsigned REG_END_CHAR      = 1;
  localparam int unsigned REG_MAX_LENGTH    = 2;
  localparam int unsigned REG_TIMEOUT_TICKS = 3;
  localparam int unsigned NUM_REGS          = 4;
  localparam int unsigned PADDR_W           = 4;

  // Reset values of the configuration registers
  localparam logic [7:0]  BEGIN_CHAR_RST    = 8'd58;
  localparam logic [7:0]  END_CHAR_RST      = 8'd10;
  localparam logic [12:0] MAX_LENGTH_RST    = 13'd64;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  // Item opcode
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Character codes
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [3:0] LETTER_BIAS = 4'd9;  // 'A' low nibble 1 maps to 10

  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_UPPER = 2'd1,
    PH_LOWER = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    K_DATA     = 3'd0,
    K_END      = 3'd1,
    K_OVERFLOW = 3'd2,
    K_BAD      = 3'd3,
    K_TIMEOUT  = 3'd4
  } kind_t;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [7:0]  begin_char;
    logic [7:0]  end_char;
    logic [12:0] max_length;
    logic [15:0] timeout_ticks;
  } cfg_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
  endfunction

  // Only valid for hex digits; digits keep their low nibble
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] n;
    if (c <= CH_DIGIT_9) begin
      n = c[3:0];
    end else begin
      n = c[3:0] + LETTER_BIAS;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ahpd_regs.sv =====
// ----------------------------------------------------------------------------
// ahpd_regs
// APB configuration registers: begin/end characters, length limit, timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module ahpd_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ahpd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output ahpd_pkg::cfg_t                    cfg
);
  import ahpd_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.begin_char    <= BEGIN_CHAR_RST;
      cfg.end_char      <= END_CHAR_RST;
      cfg.max_length    <= MAX_LENGTH_RST;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        2'(REG_BEGIN_CHAR):    cfg.begin_char    <= pwdata[7:0];
        2'(REG_END_CHAR):      cfg.end_char      <= pwdata[7:0];
        2'(REG_MAX_LENGTH):    cfg.max_length    <= pwdata[12:0];
        2'(REG_TIMEOUT_TICKS): cfg.timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      2'(REG_BEGIN_CHAR):    prdata = {24'd0, cfg.begin_char};
      2'(REG_END_CHAR):      prdata = {24'd0, cfg.end_char};
      2'(REG_MAX_LENGTH):    prdata = {19'd0, cfg.max_length};
      2'(REG_TIMEOUT_TICKS): prdata = {16'd0, cfg.timeout_ticks};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ahpd_step.sv =====
// ----------------------------------------------------------------------------
// ahpd_step
// Framing state, per-character decode and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ahpd_step #(
  parameter int unsigned MAX_PACKET = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ahpd_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           op,
  input  wire logic [7:0]     rx_char,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [2:0]          kind,
  output logic [7:0]          data_byte,
  output logic [12:0]         byte_count
);
  import ahpd_pkg::*;

  localparam logic [16:0] MAX_PACKET_W = 17'(MAX_PACKET);

  // Framing state
  phase_t      phase, phase_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [12:0] packet_count, packet_count_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  // Decode
  logic        accept;
  logic        in_pkt;
  logic        hex_ch;
  logic [3:0]  nib;
  logic [7:0]  byte_val;
  logic [12:0] count_inc;
  logic [12:0] limit;
  logic [15:0] idle_inc;
  logic        timeout_hit, byte_done, ovf_hit, end_hit, bad_hit;

  // Result
  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_data;
  logic [12:0] res_count;

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  assign in_pkt    = (phase == PH_UPPER) || (phase == PH_LOWER);
  assign hex_ch    = is_hex(rx_char);
  assign nib       = hex_nibble(rx_char);
  assign byte_val  = {high_nibble, nib};
  assign count_inc = packet_count + 13'd1;
  assign idle_inc  = (idle_ticks == IDLE_MAX) ? idle_ticks : idle_ticks + 16'd1;

  // Length limit: clamp to the build limit, zero acts as one
  always_comb begin
    if ({4'd0, cfg.max_length} > MAX_PACKET_W) begin
      limit = MAX_PACKET_W[12:0];
    end else if (cfg.max_length == 13'd0) begin
      limit = 13'd1;
    end else begin
      limit = cfg.max_length;
    end
  end

  assign timeout_hit = in_pkt & (op == OP_TICK) & (idle_inc >= cfg.timeout_ticks);
  assign byte_done   = (phase == PH_LOWER) & (op == OP_CHAR) & hex_ch;
  assign ovf_hit     = byte_done & (count_inc >= limit);
  assign end_hit     = in_pkt & (op == OP_CHAR) & ~hex_ch & (rx_char == cfg.end_char);
  assign bad_hit     = in_pkt & (op == OP_CHAR) & ~hex_ch & (rx_char != cfg.end_char);

  // Next state
  always_comb begin
    phase_next        = phase;
    high_nibble_next  = high_nibble;
    packet_count_next = packet_count;
    idle_ticks_next   = idle_ticks;
    unique case (phase)
      PH_UPPER, PH_LOWER: begin
        if (op == OP_TICK) begin
          if (timeout_hit) begin
            phase_next        = PH_HUNT;
            high_nibble_next  = 4'd0;
            packet_count_next = 13'd0;
            idle_ticks_next   = 16'd0;
          end else begin
            idle_ticks_next = idle_inc;
          end
        end else if (hex_ch) begin
          idle_ticks_next = 16'd0;
          if (phase == PH_UPPER) begin
            high_nibble_next = nib;
            phase_next       = PH_LOWER;
          end else if (ovf_hit) begin
            phase_next        = PH_HUNT;
            high_nibble_next  = 4'd0;
            packet_count_next = 13'd0;
          end else begin
            phase_next        = PH_UPPER;
            high_nibble_next  = 4'd0;
            packet_count_next = count_inc;
          end
        end else begin
          // end character or bad character both close the packet
          phase_next        = PH_HUNT;
          high_nibble_next  = 4'd0;
          packet_count_next = 13'd0;
          idle_ticks_next   = 16'd0;
        end
      end
      default: begin
        if ((op == OP_CHAR) && (rx_char == cfg.begin_char)) begin
          phase_next        = PH_UPPER;
          high_nibble_next  = 4'd0;
          packet_count_next = 13'd0;
          idle_ticks_next   = 16'd0;
        end
      end
    endcase
  end

  // Result of this item
  always_comb begin
    res_valid = timeout_hit | byte_done | end_hit | bad_hit;
    res_data  = 8'd0;
    res_count = packet_count;
    priority if (timeout_hit) begin
      res_kind = K_TIMEOUT;
    end else if (byte_done) begin
      res_kind  = ovf_hit ? K_OVERFLOW : K_DATA;
      res_data  = byte_val;
      res_count = count_inc;
    end else if (end_hit) begin
      res_kind = K_END;
    end else begin
      res_kind = K_BAD;
      res_data = rx_char;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      high_nibble  <= 4'd0;
      packet_count <= 13'd0;
      idle_ticks   <= 16'd0;
    end else if (accept) begin
      phase        <= phase_next;
      high_nibble  <= high_nibble_next;
      packet_count <= packet_count_next;
      idle_ticks   <= idle_ticks_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      kind       <= res_kind;
      data_byte  <= res_data;
      byte_count <= res_count;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ascii_hex_packet_deframer_core.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_packet_deframer_core
// Hunts for a begin character, pairs upper-case hex digits into bytes and
// reports packet end, overflow, bad character and timeout events.
// ----------------------------------------------------------------------------
// Output: a result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle; the single result register frees as it
//   is taken, so input stalls only while a result waits on out_ready.
// Reset (rst, synchronous): block hunts for begin_char, counters clear,
//   registers return to ':' / newline / 64 bytes / 1000 ticks.
`default_nettype none

module ascii_hex_packet_deframer_core #(
  parameter int unsigned MAX_PACKET = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ahpd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         op,
  input  wire logic [7:0]                   rx_char,
  // output channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [2:0]                        kind,
  output logic [7:0]                        data_byte,
  output logic [12:0]                       byte_count
);
  import ahpd_pkg::*;

  cfg_t cfg;

  ahpd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ahpd_step #(
    .MAX_PACKET (MAX_PACKET)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .rx_char    (rx_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .data_byte  (data_byte),
    .byte_count (byte_count)
  );

endmodule

`default_nettype wire
